// File: rtl/tsm7_pkg.sv
// ----------------------------------------------------------------------------
// tsm7_pkg
// Shared types, constants and the compare-exchange helper of the median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tsm7_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int BYTE_W      = 8;
    localparam int HI_FIELD_W  = 7;   // sample bits 11..5 from the first byte
    localparam int LO_FIELD_W  = 5;   // sample bits 4..0 from the second byte
    localparam int SET_LEN     = 7;
    localparam int STORE_DEPTH = 2 * SET_LEN;
    localparam int POS_W       = $clog2(STORE_DEPTH);

    localparam logic [BYTE_W-1:0] LOW7_MASK = 8'h7f;
    localparam logic [POS_W-1:0]  FIRST_POS = '0;
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(STORE_DEPTH - 1);

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SET_LEN-1:0][SAMPLE_W-1:0] set_t;

    typedef struct packed {
        sample_t lo;
        sample_t hi;
    } pair_t;

    // load enables of the two network register stages
    typedef struct packed {
        logic load_mid;
        logic load_out;
    } net_ctrl_t;

    function automatic pair_t cmp_swap(input sample_t a, input sample_t b);
        pair_t p;
        if (a > b) begin
            p.lo = b;
            p.hi = a;
        end else begin
            p.lo = a;
            p.hi = b;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tsm7_front.sv
// ----------------------------------------------------------------------------
// tsm7_front
// Input register, sample position counter, 14-entry sample store and the
// capture of a complete X/Y set.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm7_front import tsm7_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_high_byte,
    input  wire logic [BYTE_W-1:0] s_low_byte,
    input  wire logic              set_ready,
    output logic                   set_load,
    output set_t                   set_x,
    output set_t                   set_y
);

    logic             a_valid_reg;
    logic             a_last_reg;
    logic [POS_W-1:0] a_pos_reg;
    sample_t          a_sample_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             last_next;
    sample_t          sample_next;
    logic [BYTE_W-1:0] hi_masked;
    logic             accept;
    logic             a_move;
    sample_t          store_reg [STORE_DEPTH];
    set_t             set_x_reg;
    set_t             set_y_reg;

    assign hi_masked   = s_high_byte & LOW7_MASK;
    assign sample_next = {hi_masked[HI_FIELD_W-1:0], s_low_byte[BYTE_W-1 -: LO_FIELD_W]};
    assign last_next   = (pos_reg == LAST_POS);
    assign pos_next    = last_next ? FIRST_POS : pos_reg + POS_W'(1);

    // a sample that closes a set waits here until the set register is free
    assign a_move   = a_valid_reg && (!a_last_reg || set_ready);
    assign s_ready  = !a_valid_reg || a_move;
    assign accept   = s_valid && s_ready;
    assign set_load = a_valid_reg && a_last_reg && set_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            pos_reg     <= FIRST_POS;
        end else begin
            if (accept) begin
                a_valid_reg <= 1'b1;
                pos_reg     <= pos_next;
            end else if (a_move) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_last_reg   <= last_next;
            a_pos_reg    <= pos_reg;
            a_sample_reg <= sample_next;
        end
        if (a_move) begin
            store_reg[a_pos_reg] <= a_sample_reg;
        end
    end

    // take the set with the closing Y sample merged in from the input register
    always_ff @(posedge aclk) begin
        if (set_load) begin
            for (int i = 0; i < SET_LEN; i++) begin
                set_x_reg[i] <= store_reg[i];
                if (i == SET_LEN - 1) begin
                    set_y_reg[i] <= a_sample_reg;
                end else begin
                    set_y_reg[i] <= store_reg[SET_LEN + i];
                end
            end
        end
    end

    assign set_x = set_x_reg;
    assign set_y = set_y_reg;

endmodule

`default_nettype wire

// File: rtl/tsm7_median_net.sv
// ----------------------------------------------------------------------------
// tsm7_median_net
// Seven-input median from the 13-step compare-exchange network, split over
// two register stages (seven steps, then six).
// ----------------------------------------------------------------------------
`default_nettype none

module tsm7_median_net import tsm7_pkg::*; (
    input  wire logic      aclk,
    input  wire set_t      set_i,
    input  wire net_ctrl_t ctrl,
    output sample_t        median_o
);

    set_t    mid_next;
    set_t    mid_reg;
    sample_t median_next;
    sample_t median_reg;

    always_comb begin
        set_t  v;
        pair_t p;
        v = set_i;
        p = cmp_swap(v[0], v[5]); v[0] = p.lo; v[5] = p.hi;
        p = cmp_swap(v[0], v[3]); v[0] = p.lo; v[3] = p.hi;
        p = cmp_swap(v[1], v[6]); v[1] = p.lo; v[6] = p.hi;
        p = cmp_swap(v[2], v[4]); v[2] = p.lo; v[4] = p.hi;
        p = cmp_swap(v[0], v[1]); v[0] = p.lo; v[1] = p.hi;
        p = cmp_swap(v[3], v[5]); v[3] = p.lo; v[5] = p.hi;
        p = cmp_swap(v[2], v[6]); v[2] = p.lo; v[6] = p.hi;
        mid_next = v;
    end

    always_comb begin
        set_t  v;
        pair_t p;
        v = mid_reg;
        p = cmp_swap(v[2], v[3]); v[2] = p.lo; v[3] = p.hi;
        p = cmp_swap(v[3], v[6]); v[3] = p.lo; v[6] = p.hi;
        p = cmp_swap(v[4], v[5]); v[4] = p.lo; v[5] = p.hi;
        p = cmp_swap(v[1], v[4]); v[1] = p.lo; v[4] = p.hi;
        p = cmp_swap(v[1], v[3]); v[1] = p.lo; v[3] = p.hi;
        p = cmp_swap(v[3], v[4]); v[3] = p.lo; v[4] = p.hi;
        median_next = v[3];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_mid) begin
            mid_reg <= mid_next;
        end
        if (ctrl.load_out) begin
            median_reg <= median_next;
        end
    end

    assign median_o = median_reg;

endmodule

`default_nettype wire

// File: rtl/touch_sample_median7_top.sv
// ----------------------------------------------------------------------------
// touch_sample_median7_top
// Median-of-seven filter for touch-controller samples: seven X samples, then
// seven Y samples, one median pair per set of fourteen.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_high_byte[7:0], s_low_byte[7:0]
//   m_      | out       | m_valid / m_ready  | m_median_x[11:0], m_median_y[11:0]
//
// One sample transfer per cycle while s_ready is high. The fourteenth sample
// waits in the input register; the median pair then passes the set register, the
// first network half and the second network half into the output register on m_.
// Reset clears the position counter and all valid bits; store contents stay.
// A stalled result holds the set and network stages only behind it; samples
// that do not close a set keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_sample_median7_top import tsm7_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [BYTE_W-1:0]   s_high_byte,
    input  wire logic [BYTE_W-1:0]   s_low_byte,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [SAMPLE_W-1:0]      m_median_x,
    output logic [SAMPLE_W-1:0]      m_median_y
);

    logic      c_valid_reg;
    logic      d_valid_reg;
    logic      m_valid_reg;
    logic      set_ready;
    logic      set_load;
    logic      d_load;
    logic      out_load;
    net_ctrl_t net_ctrl;
    set_t      set_x;
    set_t      set_y;

    assign out_load  = d_valid_reg && (!m_valid_reg || m_ready);
    assign d_load    = c_valid_reg && (!d_valid_reg || out_load);
    assign set_ready = !c_valid_reg || d_load;

    assign net_ctrl = '{load_mid: d_load, load_out: out_load};

    tsm7_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_high_byte (s_high_byte),
        .s_low_byte  (s_low_byte),
        .set_ready   (set_ready),
        .set_load    (set_load),
        .set_x       (set_x),
        .set_y       (set_y)
    );

    tsm7_median_net u_net_x (
        .aclk     (aclk),
        .set_i    (set_x),
        .ctrl     (net_ctrl),
        .median_o (m_median_x)
    );

    tsm7_median_net u_net_y (
        .aclk     (aclk),
        .set_i    (set_y),
        .ctrl     (net_ctrl),
        .median_o (m_median_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (set_load) begin
                c_valid_reg <= 1'b1;
            end else if (d_load) begin
                c_valid_reg <= 1'b0;
            end
            if (d_load) begin
                d_valid_reg <= 1'b1;
            end else if (out_load) begin
                d_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

    // a held set is never dropped while the network stage is busy
    a_set_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && !d_load) |=> c_valid_reg)
        else $error("set register lost a pending set");

    // the network stage is only loaded from a valid set
    a_mid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        d_load |-> c_valid_reg)
        else $error("network stage loaded without a set");

    // a half-finished median waits until the output register takes it
    a_mid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (d_valid_reg && !out_load) |=> d_valid_reg)
        else $error("network stage lost a pending median");

    // the set register is never loaded while it holds a set that is not moving on
    a_set_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        set_load |-> (!c_valid_reg || d_load))
        else $error("set register overwritten");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the median-of-seven touch sample filter. Drives
// conversion byte pairs on s_ and predicts the median pair after every
// fourteenth sample. Each m_ transfer is compared with the oldest predicted
// pair. Random idle on both sides runs in two phases, then a phase with none.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import tsm7_pkg::*;

    class median7_tracker;
        sample_t     samples [STORE_DEPTH];
        int unsigned fill_pos;
        sample_t     due_x [$];
        sample_t     due_y [$];
        int unsigned mismatches;

        function new();
            fill_pos   = 0;
            mismatches = 0;
        endfunction

        task order_two(inout sample_t a, inout sample_t b);
            sample_t t;
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
        endtask

        // fixed 13-step network, same order as the hardware
        task median_of_set(input int unsigned first, output sample_t med);
            sample_t v [SET_LEN];
            for (int i = 0; i < SET_LEN; i++) v[i] = samples[first + i];
            order_two(v[0], v[5]); order_two(v[0], v[3]); order_two(v[1], v[6]);
            order_two(v[2], v[4]); order_two(v[0], v[1]); order_two(v[3], v[5]);
            order_two(v[2], v[6]); order_two(v[2], v[3]); order_two(v[3], v[6]);
            order_two(v[4], v[5]); order_two(v[1], v[4]); order_two(v[1], v[3]);
            order_two(v[3], v[4]);
            med = v[3];
        endtask

        // drop bit 7 of the first byte and bits 2..0 of the second
        task take_sample(input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo);
            sample_t mx;
            sample_t my;
            samples[fill_pos] = {hi[6:0], lo[7:3]};
            fill_pos++;
            if (fill_pos == STORE_DEPTH) begin
                fill_pos = 0;
                median_of_set(0, mx);
                median_of_set(SET_LEN, my);
                due_x.push_back(mx);
                due_y.push_back(my);
            end
        endtask

        function void match_pair(input sample_t x, input sample_t y);
            sample_t ex;
            sample_t ey;
            if (due_x.size() == 0) begin
                $error("median pair x=%0d y=%0d with none pending", x, y);
                mismatches++;
                return;
            end
            ex = due_x.pop_front();
            ey = due_y.pop_front();
            if (x !== ex) begin
                $error("median_x: expected %0d, got %0d", ex, x);
                mismatches++;
            end
            if (y !== ey) begin
                $error("median_y: expected %0d, got %0d", ey, y);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return due_x.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_high_byte = '0;
    logic [BYTE_W-1:0]   s_low_byte = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [SAMPLE_W-1:0] m_median_x;
    logic [SAMPLE_W-1:0] m_median_y;

    median7_tracker tracker = new();
    int unsigned    tx_idle_pct = 0;
    int unsigned    rx_idle_pct = 0;

    touch_sample_median7_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_high_byte (s_high_byte),
        .s_low_byte  (s_low_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_median_x  (m_median_x),
        .m_median_y  (m_median_y)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.match_pair(m_median_x, m_median_y);
    end

    // hold valid and payload until the transfer, then note the sample
    task send_bytes(input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_high_byte <= hi;
        s_low_byte  <= lo;
        do @(posedge aclk); while (!s_ready);
        tracker.take_sample(hi, lo);
    endtask

    // junk fills the busy-period null bit and the three unused low bits
    task send_value(input sample_t v, input logic [3:0] junk);
        send_bytes({junk[3], v[11:5]}, {v[4:0], junk[2:0]});
    endtask

    task send_random(input int unsigned n);
        int unsigned mode;
        sample_t     base;
        sample_t     v;
        for (int unsigned i = 0; i < n; i++) begin
            // pick a value profile per run of seven samples
            if (i % SET_LEN == 0) begin
                mode = $urandom_range(0, 3);
                base = sample_t'($urandom_range(0, 4095));
            end
            case (mode)
                0: v = sample_t'($urandom_range(0, 4095));
                1: v = base + sample_t'($urandom_range(0, 3));
                2: v = ($urandom_range(0, 2) == 0) ? base
                     : (($urandom_range(0, 1) == 0) ? sample_t'(0) : sample_t'(4095));
                default: v = base + sample_t'(i % SET_LEN);
            endcase
            send_value(v, 4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        sample_t     dir_vals [14];
        int unsigned guard;
        dir_vals = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2048, 12'd2047, 12'd2048,
                     12'd100, 12'd100, 12'd100, 12'd5, 12'd4000, 12'd100, 12'd3000};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 36;
        rx_idle_pct = 71;
        // one full set of extremes and duplicates, junk bits alternating all low and all high
        for (int i = 0; i < 14; i++) send_value(dir_vals[i], (i % 2 == 0) ? 4'h0 : 4'hf);
        send_random(184);

        tx_idle_pct = 71;
        rx_idle_pct = 36;
        send_random(184);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(182);
        s_valid <= 1'b0;

        guard = 0;
        while (tracker.pending() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (tracker.pending() != 0) begin
            $error("%0d median pairs never arrived", tracker.pending());
            tracker.mismatches++;
        end

        if (tracker.mismatches == 0) begin
            $display("PASS touch_sample_median7_top");
        end else begin
            $display("FAIL touch_sample_median7_top");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL touch_sample_median7_top");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/tsm7_pkg.sv
rtl/tsm7_front.sv
rtl/tsm7_median_net.sv
rtl/touch_sample_median7_top.sv
tb/tb_top.sv
